>>> sv/shaped_ramp_envelope_macros.svh
// Assertion macros shared by the shaped ramp envelope RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef SHAPED_RAMP_ENVELOPE_MACROS_SVH
`define SHAPED_RAMP_ENVELOPE_MACROS_SVH
`ifndef ASSERT_OFF
`define SRE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sre assertion failed");
`define SRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sre assertion failed");
`else
`define SRE_ASSERT_SAME(lbl, ante, cons)
`define SRE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/sre_pkg.sv
// Package for the shaped ramp envelope: widths, register map, types and
// the log2/exp2 tables built at elaboration. No dependencies.
`default_nettype none
package sre_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int TBL_SIZE       = 1 << LOG_TABLE_BITS;
    localparam int SH_LOG         = 31 - LOG_TABLE_BITS;
    localparam int SH_EXP         = 30 - LOG_TABLE_BITS;

    localparam int VAL_W   = 24;
    localparam int CURVE_W = 16;
    localparam int DUR_W   = 24;
    localparam int RATE_W  = 18;
    localparam int LEFT_W  = 26;
    localparam int MA_W    = 36;
    localparam int MB_W    = 33;
    localparam int MP_W    = MA_W + MB_W;
    localparam int ADDR_W  = 5;

    localparam logic [2:0] REG_SAMPLE_RATE    = 3'd0;
    localparam logic [2:0] REG_INITIAL_START  = 3'd1;
    localparam logic [2:0] REG_INITIAL_END    = 3'd2;
    localparam logic [2:0] REG_INITIAL_CURVE  = 3'd3;
    localparam logic [2:0] REG_DEFAULT_LENGTH = 3'd4;

    localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE    = 18'd44100;
    localparam logic [VAL_W-1:0]   RST_INITIAL_START  = 24'd0;
    localparam logic [VAL_W-1:0]   RST_INITIAL_END    = 24'h100000;
    localparam logic [CURVE_W-1:0] RST_INITIAL_CURVE  = 16'd4096;
    localparam logic [DUR_W-1:0]   RST_DEFAULT_LENGTH = 24'h010000;

    typedef struct packed {
        logic [RATE_W-1:0]  sample_rate;
        logic [VAL_W-1:0]   initial_start;
        logic [VAL_W-1:0]   initial_end;
        logic [CURVE_W-1:0] initial_curve;
        logic [DUR_W-1:0]   default_length;
        logic               wr_start;
        logic               wr_end;
        logic               wr_curve;
        logic [VAL_W-1:0]   wr_data;
    } cfg_t;

    typedef struct packed {
        logic               trigger;
        logic               start_present;
        logic [VAL_W-1:0]   start_value;
        logic               end_present;
        logic [VAL_W-1:0]   end_value;
        logic               curve_present;
        logic [CURVE_W-1:0] curve_value;
        logic               length_present;
        logic [DUR_W-1:0]   length_value;
    } in_item_t;

    typedef logic [31:0] tbl_t [TBL_SIZE+1];

    localparam logic [63:0] ONE30 = 64'h4000_0000;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] vv;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        vv    = v;
        for (int j = 0; j < 32; j++)
            if (bit_v > vv) bit_v = bit_v >> 2;
        for (int j = 0; j < 32; j++)
        begin
            if (bit_v != 0)
            begin
                if (vv >= res + bit_v)
                begin
                    vv  = vv - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                    res = res >> 1;
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    function automatic tbl_t build_log();
        tbl_t t;
        logic [63:0] x;
        logic [63:0] y;
        for (int i = 0; i < TBL_SIZE; i++)
        begin
            x = ONE30 + (64'(i) << (30 - LOG_TABLE_BITS));
            y = '0;
            for (int k = 0; k < 30; k++)
            begin
                x = (x * x) >> 30;
                y = y << 1;
                if (x >= 2 * ONE30)
                begin
                    x = x >> 1;
                    y = y | 64'd1;
                end
            end
            t[i] = 32'(y);
        end
        t[TBL_SIZE] = 32'(ONE30);
        return t;
    endfunction

    function automatic tbl_t build_exp();
        tbl_t t;
        logic [63:0] root [LOG_TABLE_BITS+1];
        logic [63:0] prod;
        root[0] = 2 * ONE30;
        for (int k = 1; k <= LOG_TABLE_BITS; k++)
            root[k] = isqrt64(root[k-1] << 30);
        for (int i = 0; i < TBL_SIZE; i++)
        begin
            prod = ONE30;
            for (int k = 1; k <= LOG_TABLE_BITS; k++)
                if (((i >> (LOG_TABLE_BITS - k)) & 1) != 0)
                    prod = (prod * root[k]) >> 30;
            t[i] = 32'(prod);
        end
        t[TBL_SIZE] = 32'(2 * ONE30);
        return t;
    endfunction

    localparam tbl_t LOG_TBL = build_log();
    localparam tbl_t EXP_TBL = build_exp();

endpackage
`default_nettype wire

>>> sv/sre_ifs.sv
// Request and result channel interfaces of the shaped ramp envelope.
// Depends on sre_pkg for field widths.
`default_nettype none
interface sre_in_if
    import sre_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               trigger;
    logic               start_present;
    logic [VAL_W-1:0]   start_value;
    logic               end_present;
    logic [VAL_W-1:0]   end_value;
    logic               curve_present;
    logic [CURVE_W-1:0] curve_value;
    logic               length_present;
    logic [DUR_W-1:0]   length_value;

    modport source (output valid, trigger, start_present, start_value, end_present,
                    end_value, curve_present, curve_value, length_present,
                    length_value, input ready);
    modport sink (input valid, trigger, start_present, start_value, end_present,
                  end_value, curve_present, curve_value, length_present,
                  length_value, output ready);
endinterface

interface sre_out_if
    import sre_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink (input valid, sample_out, output ready);
endinterface
`default_nettype wire

>>> sv/shaped_ramp_envelope.sv
// Shaped ramp envelope: one output sample per request, power-curve ramps.
// With no ramp running a request returns the held value; during a ramp it runs two
// power evaluations on the shared multiplier, one on its last sample; a trigger adds
// the length multiply, setup and, for lengths above one, the step divider first.
// Requests: one at a time, the next can be taken from the cycle after the result leaves.
// Reset (rst_n low, asynchronous): registers to defaults, ramp idle at 0.
`default_nettype none
`include "shaped_ramp_envelope_macros.svh"
module shaped_ramp_envelope
    import sre_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    sre_in_if.sink                 item,
    sre_out_if.source              result
);
    cfg_t            cfg;
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    logic [MP_W-1:0] mul_p;

    // writes always complete in the access cycle
    assign pready = 1'b1;

    // configuration registers; writes to the start/end/curve registers also
    // reload the live ramp parameters inside the core
    sre_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // the one multiplier: length, log/exp interpolation, curve scaling, output
    sre_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    // sequencer: divider, normalize, table lookups, ramp state, output register
    sre_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .mul_p  (mul_p)
    );

    // never take a request while a result waits
    `SRE_ASSERT_SAME(a_no_overlap, result.valid, !item.ready)
    // an accepted request closes the request side for the next cycle
    `SRE_ASSERT_NEXT(a_busy_after_req, item.valid && item.ready, !item.ready)
    // a delivered result reopens the request side and drops valid
    `SRE_ASSERT_NEXT(a_idle_after_out, result.valid && result.ready, item.ready && !result.valid)
endmodule
`default_nettype wire

>>> sv/sre_regs.sv
// APB configuration registers of the shaped ramp envelope.
// Depends on sre_pkg; drives the cfg_t bundle into the core.
`default_nettype none
module sre_regs
    import sre_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output cfg_t                   cfg
);
    logic [RATE_W-1:0]  rate_reg;
    logic [VAL_W-1:0]   start_reg;
    logic [VAL_W-1:0]   end_reg;
    logic [CURVE_W-1:0] curve_reg;
    logic [DUR_W-1:0]   len_reg;
    logic               wr;
    logic [2:0]         idx;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RST_SAMPLE_RATE;
            start_reg <= RST_INITIAL_START;
            end_reg   <= RST_INITIAL_END;
            curve_reg <= RST_INITIAL_CURVE;
            len_reg   <= RST_DEFAULT_LENGTH;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_SAMPLE_RATE:    rate_reg  <= pwdata[RATE_W-1:0];
                REG_INITIAL_START:  start_reg <= pwdata[VAL_W-1:0];
                REG_INITIAL_END:    end_reg   <= pwdata[VAL_W-1:0];
                REG_INITIAL_CURVE:  curve_reg <= pwdata[CURVE_W-1:0];
                REG_DEFAULT_LENGTH: len_reg   <= pwdata[DUR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SAMPLE_RATE:    prdata = {{(32-RATE_W){1'b0}}, rate_reg};
            REG_INITIAL_START:  prdata = {{(32-VAL_W){start_reg[VAL_W-1]}}, start_reg};
            REG_INITIAL_END:    prdata = {{(32-VAL_W){end_reg[VAL_W-1]}}, end_reg};
            REG_INITIAL_CURVE:  prdata = {{(32-CURVE_W){1'b0}}, curve_reg};
            REG_DEFAULT_LENGTH: prdata = {{(32-DUR_W){1'b0}}, len_reg};
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.sample_rate    = rate_reg;
        cfg.initial_start  = start_reg;
        cfg.initial_end    = end_reg;
        cfg.initial_curve  = curve_reg;
        cfg.default_length = len_reg;
        cfg.wr_start       = wr && (idx == REG_INITIAL_START);
        cfg.wr_end         = wr && (idx == REG_INITIAL_END);
        cfg.wr_curve       = wr && (idx == REG_INITIAL_CURVE);
        cfg.wr_data        = pwdata[VAL_W-1:0];
    end
endmodule
`default_nettype wire

>>> sv/sre_mul.sv
// Shared registered multiplier of the shaped ramp envelope.
// Depends on sre_pkg for operand widths.
`default_nettype none
module sre_mul
    import sre_pkg::*;
(
    input  wire logic            clk,
    input  wire logic [MA_W-1:0] a,
    input  wire logic [MB_W-1:0] b,
    output logic      [MP_W-1:0] prod
);
    logic [MP_W-1:0] prod_reg;

    always_ff @(posedge clk)
        prod_reg <= MP_W'(a) * MP_W'(b);

    assign prod = prod_reg;
endmodule
`default_nettype wire

>>> sv/sre_core.sv
// Sequencer of the shaped ramp envelope: ramp state, length divider,
// power evaluation and output register. Depends on sre_pkg and sre_ifs.
`default_nettype none
module sre_core
    import sre_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    sre_in_if.sink               item,
    sre_out_if.source            result,
    input  cfg_t                 cfg,
    output logic      [MA_W-1:0] mul_a,
    output logic      [MB_W-1:0] mul_b,
    input  wire logic [MP_W-1:0] mul_p
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LEN   = 4'd1;
    localparam logic [3:0] S_SET   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_LOG   = 4'd6;
    localparam logic [3:0] S_LOGS  = 4'd7;
    localparam logic [3:0] S_CURV  = 4'd8;
    localparam logic [3:0] S_CURVS = 4'd9;
    localparam logic [3:0] S_EXP   = 4'd10;
    localparam logic [3:0] S_EXPS  = 4'd11;
    localparam logic [3:0] S_MULV  = 4'd12;
    localparam logic [3:0] S_VAL   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    localparam logic [MB_W-1:0] PW_ONE = MB_W'(64'h1_0000_0000);

    logic [3:0]         state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [VAL_W-1:0]   start_reg, start_next;
    logic [VAL_W-1:0]   end_reg, end_next;
    logic [CURVE_W-1:0] curve_reg, curve_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [31:0]        phase_reg, phase_next;
    logic [31:0]        step_reg, step_next;
    logic [VAL_W-1:0]   held_reg, held_next;
    logic               first_reg, first_next;
    logic [VAL_W-1:0]   res_reg, res_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic [LEFT_W-1:0]  rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic [31:0]        norm_reg, norm_next;
    logic [4:0]         lz_reg, lz_next;
    logic [2:0]         nidx_reg, nidx_next;
    logic [MA_W-1:0]    neg_reg, neg_next;
    logic [5:0]         ip_reg, ip_next;
    logic [29:0]        g_reg, g_next;
    logic [MB_W-1:0]    pw_reg, pw_next;
    logic               pass_reg, pass_next;

    logic                      eval_go;
    logic [31:0]               eval_src;
    logic [4:0]                amt;
    logic [LOG_TABLE_BITS:0]   li, gi;
    logic [30:0]               lf;
    logic [39:0]               nt;
    logic [31:0]               e_val;
    logic [33:0]               e_sh;
    logic [24:0]               dsub;
    logic [24:0]               dmag;
    logic [58:0]               vmag;
    logic [25:0]               part;
    logic [VAL_W-1:0]          val;
    logic [LEFT_W-1:0]         cnt;
    logic [LEFT_W:0]           trial;
    logic                      qbit;
    logic [31:0]               phase_adv;

    assign item.ready     = (state_reg == S_IDLE);
    assign result.valid   = (state_reg == S_OUT);
    assign result.sample_out = res_reg;

    // Shared datapath pieces, decoded from the held working registers
    assign amt   = 5'(5'd16 >> nidx_reg);
    assign li    = {1'b0, norm_reg[30 -: LOG_TABLE_BITS]};
    assign gi    = {1'b0, g_reg[29 -: LOG_TABLE_BITS]};
    assign lf    = 31'(LOG_TBL[li]) + 31'(mul_p >> SH_LOG);
    assign nt    = mul_p[51:12];
    assign e_val = EXP_TBL[gi] + 32'(mul_p >> SH_EXP);
    assign e_sh  = {e_val, 2'b00} >> (7'(ip_reg) + 7'd1);
    assign dsub  = {end_reg[VAL_W-1], end_reg} - {start_reg[VAL_W-1], start_reg};
    assign dmag  = dsub[24] ? 25'(-dsub) : dsub;
    assign vmag  = {1'b0, mul_p[57:0]} + 59'h0_FFFF_FFFF;
    assign part  = dsub[24] ? 26'(-(vmag >> 32)) : {1'b0, mul_p[56:32]};
    assign val   = VAL_W'({{2{start_reg[VAL_W-1]}}, start_reg} + part);
    assign cnt   = (mul_p[41:16] == '0) ? LEFT_W'(1) : mul_p[41:16];
    assign qbit  = (dcnt_reg == 6'd32);
    assign trial = {rem_reg, qbit};
    assign phase_adv = phase_reg + step_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        start_next = start_reg;
        end_next   = end_reg;
        curve_next = curve_reg;
        left_next  = left_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        held_next  = held_reg;
        first_next = first_reg;
        res_next   = res_reg;
        dcnt_next  = dcnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        norm_next  = norm_reg;
        lz_next    = lz_reg;
        nidx_next  = nidx_reg;
        neg_next   = neg_reg;
        ip_next    = ip_reg;
        g_next     = g_reg;
        pw_next    = pw_reg;
        pass_next  = pass_reg;
        mul_a      = '0;
        mul_b      = '0;
        eval_go    = 1'b0;
        eval_src   = phase_reg;

        // register writes reload the live ramp parameters right away
        if (cfg.wr_start) start_next = cfg.wr_data;
        if (cfg.wr_end)   end_next   = cfg.wr_data;
        if (cfg.wr_curve) curve_next = cfg.wr_data[CURVE_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    item_next.trigger        = item.trigger;
                    item_next.start_present  = item.start_present;
                    item_next.start_value    = item.start_value;
                    item_next.end_present    = item.end_present;
                    item_next.end_value      = item.end_value;
                    item_next.curve_present  = item.curve_present;
                    item_next.curve_value    = item.curve_value;
                    item_next.length_present = item.length_present;
                    item_next.length_value   = item.length_value;
                    state_next = item.trigger ? S_LEN : S_CHK;
                end
            end
            S_LEN:
            begin
                mul_a = MA_W'(item_reg.length_present ? item_reg.length_value
                                                      : cfg.default_length);
                mul_b = MB_W'(cfg.sample_rate);
                state_next = S_SET;
            end
            S_SET:
            begin
                priority if (item_reg.start_present)
                    start_next = item_reg.start_value;
                else if (first_reg)
                    first_next = 1'b0;
                else
                    start_next = held_reg;
                if (item_reg.end_present)   end_next   = item_reg.end_value;
                if (item_reg.curve_present) curve_next = item_reg.curve_value;
                phase_next = '0;
                left_next  = cnt;
                if (cnt == LEFT_W'(1))
                begin
                    step_next  = 32'hFFFF_FFFF;
                    state_next = S_CHK;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = '0;
                    dcnt_next  = 6'd32;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // one quotient bit of 2^32 / length per cycle
                if (trial >= {1'b0, left_reg})
                begin
                    rem_next = LEFT_W'(trial - {1'b0, left_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[LEFT_W-1:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                if (dcnt_reg == '0)
                begin
                    step_next  = quo_next;
                    state_next = S_CHK;
                end
                else
                    dcnt_next = dcnt_reg - 6'd1;
            end
            S_CHK:
            begin
                if (left_reg == '0)
                begin
                    res_next   = held_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    eval_go   = 1'b1;
                    eval_src  = phase_reg;
                    pass_next = 1'b0;
                end
            end
            S_NORM:
            begin
                if ((norm_reg >> (6'd32 - 6'(amt))) == '0)
                begin
                    norm_next = norm_reg << amt;
                    lz_next   = lz_reg + amt;
                end
                nidx_next = nidx_reg + 3'd1;
                if (nidx_reg == 3'd4) state_next = S_LOG;
            end
            S_LOG:
            begin
                mul_a = MA_W'(LOG_TBL[li + 1'b1] - LOG_TBL[li]);
                mul_b = MB_W'(norm_reg[SH_LOG-1:0]);
                state_next = S_LOGS;
            end
            S_LOGS:
            begin
                neg_next   = ((MA_W'(lz_reg) + MA_W'(1)) << 30) - MA_W'(lf);
                state_next = S_CURV;
            end
            S_CURV:
            begin
                mul_a = neg_reg;
                mul_b = MB_W'(curve_reg);
                state_next = S_CURVS;
            end
            S_CURVS:
            begin
                if (nt[29:0] == '0)
                begin
                    pw_next = (nt[39:30] >= 10'd33) ? '0 : (PW_ONE >> nt[39:30]);
                    state_next = S_MULV;
                end
                else if (nt[39:30] >= 10'd33)
                begin
                    pw_next    = '0;
                    state_next = S_MULV;
                end
                else
                begin
                    g_next     = 30'(31'h4000_0000 - {1'b0, nt[29:0]});
                    ip_next    = nt[35:30];
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                mul_a = MA_W'(EXP_TBL[gi + 1'b1] - EXP_TBL[gi]);
                mul_b = MB_W'(g_reg[SH_EXP-1:0]);
                state_next = S_EXPS;
            end
            S_EXPS:
            begin
                pw_next    = e_sh[MB_W-1:0];
                state_next = S_MULV;
            end
            S_MULV:
            begin
                mul_a = MA_W'(dmag);
                mul_b = pw_reg;
                state_next = S_VAL;
            end
            S_VAL:
            begin
                if (!pass_reg)
                begin
                    res_next   = val;
                    left_next  = left_reg - LEFT_W'(1);
                    phase_next = phase_adv;
                    if (left_reg == LEFT_W'(1))
                    begin
                        held_next  = end_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        eval_go   = 1'b1;
                        eval_src  = phase_adv;
                        pass_next = 1'b1;
                    end
                end
                else
                begin
                    held_next  = val;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (result.ready) state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        // start a power evaluation; zero curve and zero phase skip the tables
        if (eval_go)
        begin
            norm_next = eval_src;
            lz_next   = '0;
            nidx_next = '0;
            priority if (curve_next == '0)
            begin
                pw_next    = PW_ONE;
                state_next = S_MULV;
            end
            else if (eval_src == '0)
            begin
                pw_next    = '0;
                state_next = S_MULV;
            end
            else
                state_next = S_NORM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= RST_INITIAL_START;
            end_reg   <= RST_INITIAL_END;
            curve_reg <= RST_INITIAL_CURVE;
            left_reg  <= '0;
            phase_reg <= '0;
            step_reg  <= '0;
            held_reg  <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            curve_reg <= curve_next;
            left_reg  <= left_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            held_reg  <= held_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        dcnt_reg <= dcnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        norm_reg <= norm_next;
        lz_reg   <= lz_next;
        nidx_reg <= nidx_next;
        neg_reg  <= neg_next;
        ip_reg   <= ip_next;
        g_reg    <= g_next;
        pw_reg   <= pw_next;
        pass_reg <= pass_next;
    end
endmodule
`default_nettype wire

>>> sim/sre_checker.sv
// Ramp sample checker: watches the register port and both channels, predicts
// each output sample and compares it. Depends on sre_pkg and sre_ifs.
`timescale 1ns / 1ps
module sre_checker
    import sre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    sre_in_if                 item_mon,
    sre_out_if                result_mon,
    output int                mismatches,
    output int                samples_pending
);
    localparam int LB = 8;
    localparam int TS = 1 << LB;
    localparam longint unsigned UNITY = 64'h4000_0000;

    longint unsigned log_t [TS+1];
    longint unsigned exp_t [TS+1];

    // model copy of registers and ramp state
    logic [17:0]        rate_q;
    logic signed [23:0] start_reg, end_reg;
    logic [15:0]        curve_reg;
    logic [23:0]        dur_reg;
    logic signed [23:0] ramp_from, ramp_to, held_q;
    logic [15:0]        ramp_curve_q;
    logic [25:0]        left_q;
    logic [31:0]        phase_q, step_q;
    logic               first_q;

    logic [23:0] sample_queue [$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    initial
    begin
        longint unsigned roots [LB+1];
        longint unsigned x, y, prod;
        roots[0] = 2 * UNITY;
        for (int k = 1; k <= LB; k++) roots[k] = int_sqrt(roots[k-1] << 30);
        for (int i = 0; i < TS; i++)
        begin
            x = UNITY + (longint'(i) << (30 - LB));
            y = 0;
            prod = UNITY;
            for (int k = 0; k < 30; k++)
            begin
                x = (x * x) >> 30;
                y = y << 1;
                if (x >= 2 * UNITY)
                begin
                    x = x >> 1;
                    y = y | 1;
                end
            end
            log_t[i] = y;
            for (int k = 1; k <= LB; k++)
                if (((i >> (LB - k)) & 1) != 0) prod = (prod * roots[k]) >> 30;
            exp_t[i] = prod;
        end
        log_t[TS] = UNITY;
        exp_t[TS] = 2 * UNITY;
    end

    // phase^curve in Q0.32 via log2 / exp2 interpolation
    function automatic longint unsigned curve_power(logic [31:0] p, logic [15:0] c);
        int k;
        longint unsigned frac, idx, rem, lf, neg, nt, ip, fp, g, e;
        if (c == 0) return 64'h1_0000_0000;
        if (p == 0) return 0;
        k = 31;
        while (!p[k]) k--;
        frac = ({32'd0, p} << (31 - k)) & 64'h7FFF_FFFF;
        idx = frac >> (31 - LB);
        rem = frac & ((64'd1 << (31 - LB)) - 1);
        lf = log_t[idx] + (((log_t[idx+1] - log_t[idx]) * rem) >> (31 - LB));
        neg = longint'(32 - k) * UNITY - lf;
        nt = (neg * c) >> 12;
        ip = nt >> 30;
        fp = nt & (UNITY - 1);
        if (fp == 0) return (ip >= 33) ? 0 : (64'h1_0000_0000 >> ip);
        if (ip + 1 >= 34) return 0;
        g = UNITY - fp;
        idx = g >> (30 - LB);
        rem = g & ((64'd1 << (30 - LB)) - 1);
        e = exp_t[idx] + (((exp_t[idx+1] - exp_t[idx]) * rem) >> (30 - LB));
        return (e << 2) >> (ip + 1);
    endfunction

    function automatic logic signed [23:0] ramp_point(logic [31:0] p, logic signed [23:0] a,
                                                      logic signed [23:0] b, logic [15:0] c);
        longint diff, prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(curve_power(p, c));
        // arithmetic shift floors toward minus infinity
        return 24'(longint'(a) + (prod >>> 32));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [41:0] cnt;
        logic [23:0] dur;
        logic [23:0] got, want;
        logic signed [23:0] sample;
        if (!rst_n)
        begin
            rate_q       = RST_SAMPLE_RATE;
            start_reg    = RST_INITIAL_START;
            end_reg      = RST_INITIAL_END;
            curve_reg    = RST_INITIAL_CURVE;
            dur_reg      = RST_DEFAULT_LENGTH;
            ramp_from    = RST_INITIAL_START;
            ramp_to      = RST_INITIAL_END;
            ramp_curve_q = RST_INITIAL_CURVE;
            left_q       = '0;
            phase_q      = '0;
            step_q       = '0;
            held_q       = '0;
            first_q      = 1'b1;
            mismatches   = 0;
            sample_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_SAMPLE_RATE:    rate_q = pwdata[17:0];
                    REG_INITIAL_START:
                    begin
                        start_reg = pwdata[23:0];
                        ramp_from = start_reg;
                    end
                    REG_INITIAL_END:
                    begin
                        end_reg = pwdata[23:0];
                        ramp_to = end_reg;
                    end
                    REG_INITIAL_CURVE:
                    begin
                        curve_reg    = pwdata[15:0];
                        ramp_curve_q = curve_reg;
                    end
                    REG_DEFAULT_LENGTH: dur_reg = pwdata[23:0];
                    default: ;
                endcase
            end
            if (item_mon.valid && item_mon.ready)
            begin
                if (item_mon.trigger)
                begin
                    dur = item_mon.length_present ? item_mon.length_value : dur_reg;
                    cnt = (42'(dur) * 42'(rate_q)) >> 16;
                    if (cnt == 0) cnt = 1;
                    if (item_mon.start_present) ramp_from = item_mon.start_value;
                    else if (first_q)
                        first_q = 1'b0;
                    else
                        ramp_from = held_q;
                    if (item_mon.end_present) ramp_to = item_mon.end_value;
                    if (item_mon.curve_present) ramp_curve_q = item_mon.curve_value;
                    phase_q = '0;
                    step_q  = (cnt == 1) ? 32'hFFFF_FFFF : 32'(64'h1_0000_0000 / cnt);
                    left_q  = cnt[25:0];
                end
                if (left_q == 0)
                    sample = held_q;
                else
                begin
                    sample  = ramp_point(phase_q, ramp_from, ramp_to, ramp_curve_q);
                    left_q  = left_q - 26'd1;
                    phase_q = phase_q + step_q;
                    held_q  = (left_q == 0) ? ramp_to
                            : ramp_point(phase_q, ramp_from, ramp_to, ramp_curve_q);
                end
                sample_queue.push_back(sample);
            end
            if (result_mon.valid && result_mon.ready)
            begin
                got = result_mon.sample_out;
                if (sample_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sample_out %h at %0t", got, $realtime);
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample_out mismatch: expected %h actual %h at %0t",
                                     want, got, $realtime);
                    end
                end
            end
        end
        samples_pending = sample_queue.size();
    end
endmodule

>>> sim/testbench.sv
// Top of the ramp envelope testbench: clock, reset, register writes and
// request traffic. Depends on sre_pkg, sre_ifs, the block and sre_checker.
`timescale 1ns / 1ps
module testbench;
    import sre_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                mismatches;
    int                samples_pending;

    sre_in_if  req_ch ();
    sre_out_if res_ch ();

    shaped_ramp_envelope dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item(req_ch.sink), .result(res_ch.source)
    );

    sre_checker chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .item_mon(req_ch), .result_mon(res_ch),
        .mismatches(mismatches), .samples_pending(samples_pending)
    );

    // sample rate currently programmed, used to size short ramps
    logic [17:0] cur_rate;
    // when set, neither side inserts idle cycles
    logic        no_idle;
    int          requests_sent;
    int          triggers_sent;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // hard stop in case the handshake hangs
    initial
    begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: drop ready in random bursts, unless idling is off
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end
        else
            res_ch.ready <= 1'b1;
    end

    // one register write: setup phase, access phase until pready, then back to idle
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SAMPLE_RATE) cur_rate = val[17:0];
        @(posedge clk);
    endtask

    // hold the request until the block takes it
    task automatic send_request(input in_item_t r);
        req_ch.valid          <= 1'b1;
        req_ch.trigger        <= r.trigger;
        req_ch.start_present  <= r.start_present;
        req_ch.start_value    <= r.start_value;
        req_ch.end_present    <= r.end_present;
        req_ch.end_value      <= r.end_value;
        req_ch.curve_present  <= r.curve_present;
        req_ch.curve_value    <= r.curve_value;
        req_ch.length_present <= r.length_present;
        req_ch.length_value   <= r.length_value;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        requests_sent++;
        if (r.trigger) triggers_sent++;
        // random gap after the request, unless idling is off
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // drain all results, then give the block its worst-case latency
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (samples_pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic in_item_t make_request(logic trig, logic sp, logic [23:0] sv,
                                              logic ep, logic [23:0] ev, logic cp,
                                              logic [15:0] cv, logic lp, logic [23:0] lv);
        in_item_t r;
        r.trigger = trig;
        r.start_present = sp;
        r.start_value = sv;
        r.end_present = ep;
        r.end_value = ev;
        r.curve_present = cp;
        r.curve_value = cv;
        r.length_present = lp;
        r.length_value = lv;
        return r;
    endfunction

    // mostly well-formed ramps of a few dozen samples, some raw noise
    function automatic in_item_t random_request();
        in_item_t r;
        int          pick;
        logic [41:0] dur;
        r = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 85)
        begin
            r.trigger = ($urandom_range(0, 11) == 0);
            if (cur_rate == 0)
                dur = 42'($urandom);
            else
                dur = (42'($urandom_range(0, 40)) << 16) / cur_rate;
            r.length_value = (dur > 42'hFF_FFFF) ? 24'hFF_FFFF : dur[23:0];
            if ($urandom_range(0, 9) == 0) r.length_value = '0;
            if ($urandom_range(0, 3) == 0) r.curve_value = 16'($urandom_range(0, 16384));
        end
        else if (pick < 90)
        begin
            // ramp trigger with a full-range random duration when the length is present
            r.trigger = 1'b1;
        end
        return r;
    endfunction

    localparam logic [23:0] VMAX = 24'h7F_FFFF;
    localparam logic [23:0] VMIN = 24'h80_0000;

    initial
    begin
        in_item_t q [$];
        int n;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.trigger = 1'b0;
        req_ch.start_present = 1'b0;
        req_ch.start_value = '0;
        req_ch.end_present = 1'b0;
        req_ch.end_value = '0;
        req_ch.curve_present = 1'b0;
        req_ch.curve_value = '0;
        req_ch.length_present = 1'b0;
        req_ch.length_value = '0;
        cur_rate = RST_SAMPLE_RATE;
        no_idle = 1'b0;
        requests_sent = 0;
        triggers_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: output before any ramp, first ramp from the stored start
        send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(1, 0, 0, 0, 0, 0, 0, 1, 24'd6));
        repeat (4) send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // glide from the held value; zero length gives a single sample
        send_request(make_request(1, 0, 0, 1, VMIN, 1, 16'hFFFF, 1, 24'd0));
        send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // extremes of start and end, zero curve, then tiny and steep curves
        send_request(make_request(1, 1, VMAX, 1, VMIN, 1, 16'd0, 1, 24'd3));
        repeat (3) send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(1, 1, VMIN, 1, VMAX, 1, 16'd1, 1, 24'd5));
        repeat (4) send_request(make_request(0, 1, VMAX, 1, 0, 1, 0, 1, 0));
        send_request(make_request(1, 1, VMIN, 1, VMAX, 1, 16'hFFFF, 1, 24'd4));
        repeat (3) send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // retrigger after the ramp has ended, with the longest duration
        send_request(make_request(1, 0, 0, 0, 0, 0, 0, 1, 24'hFF_FFFF));
        send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // register settings, extremes first; sample rate zero forces length one
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    reg_write(REG_SAMPLE_RATE, 32'd1);
                    reg_write(REG_INITIAL_START, {8'd0, VMIN});
                    reg_write(REG_INITIAL_END, {8'd0, VMAX});
                    reg_write(REG_INITIAL_CURVE, 32'd0);
                    reg_write(REG_DEFAULT_LENGTH, 32'hFF_FFFF);
                end
                1:
                begin
                    reg_write(REG_SAMPLE_RATE, 32'd192000);
                    reg_write(REG_INITIAL_START, {8'd0, VMAX});
                    reg_write(REG_INITIAL_END, {8'd0, VMIN});
                    reg_write(REG_INITIAL_CURVE, 32'hFFFF);
                    reg_write(REG_DEFAULT_LENGTH, 32'd0);
                end
                2:
                begin
                    reg_write(REG_SAMPLE_RATE, 32'd0);
                    reg_write(REG_DEFAULT_LENGTH, 32'd10);
                end
                default:
                begin
                    reg_write(REG_SAMPLE_RATE, $urandom_range(1, 192000));
                    reg_write(REG_INITIAL_START, {8'd0, 24'($urandom)});
                    reg_write(REG_INITIAL_END, {8'd0, 24'($urandom)});
                    reg_write(REG_INITIAL_CURVE, $urandom_range(0, 65535));
                    reg_write(REG_DEFAULT_LENGTH, (32'($urandom_range(1, 30)) << 16)
                                                  / (cur_rate + 1));
                end
            endcase
            // writes past the last register must be ignored
            reg_write(3'd5 + 3'($urandom_range(0, 2)), $urandom);
            n = (ph == 5) ? 330 : 210;
            for (int i = 0; i < n; i++)
            begin
                // idling off for the tail of the run
                if (ph == 5 && i == 180) no_idle = 1'b1;
                // hold off once mid-phase until every sample is back
                if (ph == 3 && i == 100) wait_drained();
                send_request(random_request());
            end
            wait_drained();
        end

        repeat (80) @(posedge clk);
        $display("Covered %0d requests with %0d ramp triggers across seven register settings.",
                 requests_sent, triggers_sent);
        if (mismatches == 0 && samples_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
